// ----- rtl/sha384_pkg.sv -----
// Shared types, constants and round functions of the SHA-384 hash engine.
package sha384_pkg;

    localparam int WordWidth = 64;
    localparam int BlockWords = 16;
    localparam int Rounds = 80;
    localparam int DigestWords = 6;

    typedef logic [WordWidth-1:0] word_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_word;   // write sched_word into the block buffer
        word_t      sched_word;
        logic       start;       // copy chaining values into a..h
        logic       round;       // run one round
        logic [6:0] round_idx;
        logic       finish;      // add a..h into chaining values
        logic       reinit;      // reload initial values
        logic [2:0] out_idx;
    } sha384_cmd_t;

    function automatic word_t init_value(input logic [2:0] idx);
        word_t v;
        v = '0;
        case (idx)
            3'd0: v = 64'hcbbb9d5dc1059ed8;
            3'd1: v = 64'h629a292a367cd507;
            3'd2: v = 64'h9159015a3070dd17;
            3'd3: v = 64'h152fecd8f70e5939;
            3'd4: v = 64'h67332667ffc00b31;
            3'd5: v = 64'h8eb44a8768581511;
            3'd6: v = 64'hdb0c2e0d64f98fa7;
            default: v = 64'h47b5481dbefa4fa4;
        endcase
        return v;
    endfunction

    function automatic word_t round_const(input logic [6:0] r);
        word_t k;
        k = '0;
        case (r)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordWidth - n));
    endfunction

endpackage

// ----- rtl/sha384_hash_engine.sv -----
// Top level of the SHA-384 hash engine.
// SHA-384 over a stream of big-endian 64-bit words. Every 16th word starts a
// compression (load, 80 rounds of the single round unit, fold), during which
// no request is taken; other words are only stored in the block buffer.
// On the last word the engine appends padding and length one word per cycle,
// compresses one or two blocks, then offers h0..h5 as six results and
// reloads the initial values.
module sha384_hash_engine
    import sha384_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // message_word[63:0], byte_count[67:64], zero fill
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word[63:0]
    output logic [2:0]  m_tuser,   // word_index[2:0]
    output logic        m_tlast    // last_out
);

    sha384_cmd_t cmd;
    logic [2:0]  idx;

    sha384_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata[63:0]),
        .in_count  (s_tdata[67:64]),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_idx   (idx),
        .cmd       (cmd)
    );

    sha384_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .digest_word (m_tdata)
    );

    assign m_tuser = idx;
    assign m_tlast = (idx == 3'(DigestWords - 1));

endmodule

// ----- rtl/sha384_datapath.sv -----
// Block buffer, round logic and chaining values of the SHA-384 engine.
module sha384_datapath
    import sha384_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sha384_cmd_t cmd,
    output word_t       digest_word
);

    word_t w_reg [BlockWords];
    word_t h_reg [8];
    word_t v_reg [8];
    word_t w_new, wr, t1, t2, s0, s1, x15, x2;
    logic [3:0] ri, ri2, ri7, ri15, wpos_reg, wpos_next;

    // Compute schedule word and round terms
    always_comb begin
        ri   = cmd.round_idx[3:0];
        ri2  = ri - 4'd2;
        ri7  = ri - 4'd7;
        ri15 = ri - 4'd15;
        x15  = w_reg[ri15];
        x2   = w_reg[ri2];
        s0   = rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7);
        s1   = rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6);
        w_new = w_reg[ri] + s0 + w_reg[ri7] + s1;
        wr   = (cmd.round_idx < 7'd16) ? w_reg[ri] : w_new;
        t1 = v_reg[7] + (rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + round_const(cmd.round_idx) + wr;
        t2 = (rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        wpos_next = wpos_reg + 4'd1;
    end

    // Fill the block buffer and advance the rounds
    always_ff @(posedge aclk) begin
        if (cmd.load_word) begin
            w_reg[wpos_reg] <= cmd.sched_word;
        end else if (cmd.round && cmd.round_idx >= 7'd16) begin
            w_reg[ri] <= w_new;
        end
        if (cmd.start) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end else if (cmd.round) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // Hold chaining values and buffer fill position
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reinit) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= init_value(3'(i));
            wpos_reg <= '0;
        end else begin
            if (cmd.finish) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (cmd.load_word) wpos_reg <= wpos_next;
        end
    end

    assign digest_word = h_reg[cmd.out_idx];

endmodule

// ----- rtl/sha384_ctrl.sv -----
// Controller: input acceptance, padding sequence, rounds and digest output.
module sha384_ctrl
    import sha384_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  word_t       in_word,
    input  logic [3:0]  in_count,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_idx,
    output sha384_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_START = 6'b000100,
        S_ROUND = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] wpos_reg, wpos_next;
    logic [63:0] len_reg, len_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] oidx_reg, oidx_next;
    logic       final_reg, final_next;   // padding appended, emit after compress
    logic       extra_reg, extra_next;   // pad word 0x80.. still owed
    logic       pad_reg, pad_next;       // padding in progress
    logic       late_reg, late_next;     // pad byte took word 14, length moves to next block
    logic [3:0] cnt;
    logic [63:0] mask, padded;

    // Truncate and pad the last word
    always_comb begin
        cnt = (in_count > 4'd8 || !in_last) ? 4'd8 : in_count;
        mask = (cnt == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {cnt, 3'b000});
        padded = (in_word & mask) | (64'h8000000000000000 >> {cnt, 3'b000});
    end

    always_comb begin
        state_next = state_reg;
        wpos_next = wpos_reg;
        len_next = len_reg;
        rnd_next = rnd_reg;
        oidx_next = oidx_reg;
        final_next = final_reg;
        extra_next = extra_reg;
        pad_next = pad_reg;
        late_next = late_reg;
        cmd = '0;
        cmd.round_idx = rnd_reg;
        cmd.out_idx = oidx_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    len_next = len_reg + {57'd0, cnt, 3'b000};
                    cmd.load_word = 1'b1;
                    wpos_next = wpos_reg + 4'd1;
                    if (in_last) begin
                        pad_next = 1'b1;
                        extra_next = (cnt == 4'd8);
                        late_next = (cnt != 4'd8) && (wpos_reg == 4'd14);
                        cmd.sched_word = (cnt == 4'd8) ? in_word : padded;
                    end else begin
                        cmd.sched_word = in_word;
                    end
                    if (wpos_reg == 4'd15) state_next = S_START;
                    else if (in_last) state_next = S_PAD;
                end
            end
            S_PAD: begin
                // Append one padding word per cycle
                cmd.load_word = 1'b1;
                wpos_next = wpos_reg + 4'd1;
                if (extra_reg) begin
                    cmd.sched_word = 64'h8000000000000000;
                    extra_next = 1'b0;
                    late_next = (wpos_reg == 4'd14);
                end else if (wpos_reg == 4'd15 && !late_reg) begin
                    cmd.sched_word = len_reg;
                    final_next = 1'b1;
                end else begin
                    cmd.sched_word = '0;
                    late_next = 1'b0;
                end
                if (wpos_reg == 4'd15) state_next = S_START;
            end
            S_START: begin
                cmd.start = 1'b1;
                rnd_next = '0;
                state_next = S_ROUND;
            end
            S_ROUND: begin
                cmd.round = 1'b1;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'(Rounds - 1)) state_next = S_FIN;
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                rnd_next = '0;
                if (final_reg) begin
                    oidx_next = '0;
                    state_next = S_OUT;
                end else if (pad_reg) begin
                    state_next = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'(DigestWords - 1)) begin
                        cmd.reinit = 1'b1;
                        len_next = '0;
                        wpos_next = '0;
                        final_next = 1'b0;
                        pad_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_idx = oidx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wpos_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
            oidx_reg <= '0;
            final_reg <= 1'b0;
            extra_reg <= 1'b0;
            pad_reg <= 1'b0;
            late_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wpos_reg <= wpos_next;
            len_reg <= len_next;
            rnd_reg <= rnd_next;
            oidx_reg <= oidx_next;
            final_reg <= final_next;
            extra_reg <= extra_next;
            pad_reg <= pad_next;
            late_reg <= late_next;
        end
    end

endmodule
